// ----- rtl/core/p80_pkg.sv -----
package p80_pkg;

    localparam int BLOCK_W = 64;
    localparam int KEY_W   = 80;
    localparam int KHI_W   = 16;
    localparam int RC_W    = 5;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 64;

    typedef logic [BLOCK_W-1:0] block_t;
    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [RC_W-1:0]    rc_t;

    // register select, taken from paddr bit 3 (8-byte spacing)
    typedef enum logic
    {
        REG_KEY_LOW  = 1'b0,
        REG_KEY_HIGH = 1'b1
    } reg_sel_t;

    localparam logic [3:0] SBOX [16] = '{
        4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
        4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
    };

    // 4-bit substitution
    function automatic logic [3:0] sbox4(input logic [3:0] x);
        return SBOX[x];
    endfunction

    // substitution on all 16 nibbles
    function automatic block_t sub_layer(input block_t x);
        block_t r;
        r = '0;
        for (int n = 0; n < 16; n++)
        begin
            r[4*n +: 4] = sbox4(x[4*n +: 4]);
        end
        return r;
    endfunction

    // bit i goes to 16*i mod 63, bit 63 stays
    function automatic block_t perm_layer(input block_t x);
        block_t r;
        r = '0;
        for (int i = 0; i < BLOCK_W; i++)
        begin
            if (i == BLOCK_W - 1)
            begin
                r[BLOCK_W-1] = x[i];
            end
            else
            begin
                r[(i * 16) % 63] = x[i];
            end
        end
        return r;
    endfunction

    // round key is key bits 79..16
    function automatic block_t round_key(input key_t k);
        return k[KEY_W-1 -: BLOCK_W];
    endfunction

endpackage

// ----- rtl/core/p80_round_cell.sv -----
module p80_round_cell #(
    parameter int ROUND_NUM = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  p80_pkg::block_t in_state,
    input  p80_pkg::key_t   in_key,
    output logic            out_valid,
    input  logic            out_ready,
    output p80_pkg::block_t out_state,
    output p80_pkg::key_t   out_key
);
    import p80_pkg::*;

    localparam rc_t RoundBits = RC_W'(ROUND_NUM);

    logic   valid_reg;
    block_t state_reg;
    key_t   key_reg;
    block_t state_next;
    key_t   key_next;
    key_t   key_rot;

    // key schedule: rotate left 61, s-box on top nibble, round number into 19..15
    always_comb
    begin
        key_rot = {in_key[18:0], in_key[KEY_W-1:19]};
        key_next = key_rot;
        key_next[KEY_W-1 -: 4] = sbox4(key_rot[KEY_W-1 -: 4]);
        key_next[19:15] = key_rot[19:15] ^ RoundBits;
    end

    // round datapath
    assign state_next = perm_layer(sub_layer(in_state)) ^ round_key(key_next);

    // cell takes a word when empty or when its neighbor takes the held one
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            state_reg <= state_next;
            key_reg   <= key_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;
    assign out_key   = key_reg;

endmodule

// ----- rtl/core/present80_block_encrypt.sv -----
// channel     | signals                          | word
// ------------+----------------------------------+---------------------------
// input       | in_valid / in_ready              | plaintext (64 bits)
// output      | out_valid / out_ready            | ciphertext (64 bits)
// config      | psel penable pwrite paddr pwdata | key_low @0x0, key_high @0x8
//
// one word per cycle sustained while out_ready is high; each word passes
// through the chain of round cells, one registered cell per round.
// a stalled output only holds cells that are occupied: empty cells still fill.
// rst_n clears all cell valid bits and both key registers.
module present80_block_encrypt #(
    parameter int ROUND_COUNT = 31
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  p80_pkg::block_t               plaintext,
    output logic                          out_valid,
    input  logic                          out_ready,
    output p80_pkg::block_t               ciphertext,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [p80_pkg::ADDR_W-1:0]    paddr,
    input  logic [p80_pkg::DATA_W-1:0]    pwdata,
    output logic [p80_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import p80_pkg::*;

    logic [BLOCK_W-1:0]       key_low_reg;
    logic [KHI_W-1:0]         key_high_reg;
    logic                     cfg_wr;
    reg_sel_t                 cfg_sel;

    logic                     chain_valid [ROUND_COUNT+1];
    logic                     chain_ready [ROUND_COUNT+1];
    block_t                   chain_state [ROUND_COUNT+1];
    key_t                     chain_key   [ROUND_COUNT+1];

    // register port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = reg_sel_t'(paddr[3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                REG_KEY_LOW:  key_low_reg  <= pwdata;
                REG_KEY_HIGH: key_high_reg <= pwdata[KHI_W-1:0];
                default:      key_low_reg  <= key_low_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_KEY_LOW:  prdata = key_low_reg;
            REG_KEY_HIGH: prdata = {{(DATA_W-KHI_W){1'b0}}, key_high_reg};
            default:      prdata = '0;
        endcase
    end

    // chain head: initial key whitening
    assign chain_valid[0] = in_valid;
    assign in_ready       = chain_ready[0];
    assign chain_key[0]   = {key_high_reg, key_low_reg};
    assign chain_state[0] = plaintext ^ round_key(chain_key[0]);

    // one cell per round
    for (genvar g = 0; g < ROUND_COUNT; g++)
    begin : g_round
        p80_round_cell #(
            .ROUND_NUM (g + 1)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[g]),
            .in_ready  (chain_ready[g]),
            .in_state  (chain_state[g]),
            .in_key    (chain_key[g]),
            .out_valid (chain_valid[g+1]),
            .out_ready (chain_ready[g+1]),
            .out_state (chain_state[g+1]),
            .out_key   (chain_key[g+1])
        );
    end

    // chain tail is the output register
    assign chain_ready[ROUND_COUNT] = out_ready;
    assign out_valid  = chain_valid[ROUND_COUNT];
    assign ciphertext = chain_state[ROUND_COUNT];

endmodule

// ----- rtl/core/p80_checker.sv -----
module p80_checker #(
    parameter int ROUND_COUNT = 31
) (
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input logic            out_valid,
    input logic            out_ready,
    input p80_pkg::block_t ciphertext,
    input logic            pready
);
    import p80_pkg::*;

    localparam int CntW = $clog2(ROUND_COUNT + 2);

    logic [CntW-1:0] cnt_reg;
    logic [CntW-1:0] cnt_next;

    // words in flight
    always_comb
    begin
        cnt_next = cnt_reg;
        if (in_valid && in_ready)
        begin
            cnt_next = cnt_next + CntW'(1);
        end
        if (out_valid && out_ready)
        begin
            cnt_next = cnt_next - CntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(ciphertext))
        else $error("output word changed while stalled");

    // no output word without one in flight
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cnt_reg != '0)
        else $error("output word with nothing in flight");

    // never more words than cells
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CntW'(ROUND_COUNT))
        else $error("more words in flight than round cells");

    // empty tail means the chain accepts
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while output is empty");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("register port not ready");

endmodule

bind present80_block_encrypt p80_checker #(
    .ROUND_COUNT (ROUND_COUNT)
) u_p80_checker (.*);
